@@ sv/mrq_pkg.sv @@
`timescale 1ns / 1ps
package mrq_pkg;
  localparam int LEVELS_DEF = 4;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int COST_W = 17;
  localparam int ID_W = 8;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic CFG_NULL_LEVEL = 1'b0;
  localparam logic CFG_FIFO_LEVEL = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic is_null;
    logic [COST_W-1:0] cost;
  } entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] process_id;
    logic [1:0] level;
    logic no_process;
  } result_t;
endpackage

@@ sv/mrq_store.sv @@
`timescale 1ns / 1ps
// Entry memory: one write port, one registered read port.
module mrq_store import mrq_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/multilevel_ready_queue.sv @@
`timescale 1ns / 1ps
// Sequential ready queue: one command at a time, entries kept in one memory.
// Full push, empty pop and unused or no-op remove touch no memory; an append writes
// the tail; pop and found remove read, then shift the level up; a missed remove scans
// the level; head push shifts it down; ordered push scans from the tail, then shifts.
// Next command is taken the cycle after the result beat.
// Sync active-low reset clears counts and control, presets the levels; memory undefined.
module multilevel_ready_queue import mrq_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], process_id[9:2], level[11:10], no_process[12], ran_before[13],
  // burst_time[29:14], io_time[45:30], zero pad to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], out_process_id[9:2], out_level[11:10], out_no_process[12], pad
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int CW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = LW + PW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r [LEVELS];
  logic [1:0] null_lvl_r, fifo_lvl_r;
  logic [1:0] cmd_r, cmd_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  entry_t new_r, new_nxt;
  logic [CW-1:0] idx_r, idx_nxt;   // scan / shift pointer
  logic [CW-1:0] pos_r, pos_nxt;   // insert or delete position
  result_t res_r, res_nxt;
  logic out_v_r, out_v_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  mrq_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [LW-1:0] clamp(input logic [1:0] v);
    if (32'(v) >= LEVELS) clamp = LW'(LEVELS - 1);
    else clamp = LW'(v);
  endfunction

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [CW-1:0] p);
    addr = {l, p[PW-1:0]};
  endfunction

  logic [1:0] i_cmd, i_lvl;
  logic [7:0] i_pid;
  logic i_nop, i_ran;
  logic [COST_W-1:0] i_cost;
  assign i_cmd = in_tdata[1:0];
  assign i_pid = in_tdata[9:2];
  assign i_lvl = in_tdata[11:10];
  assign i_nop = in_tdata[12];
  assign i_ran = in_tdata[13];
  assign i_cost = COST_W'(in_tdata[29:14]) + COST_W'(in_tdata[45:30]);

  logic [LW-1:0] push_lvl;
  assign push_lvl = i_nop ? clamp(null_lvl_r) : clamp(i_lvl);

  // lowest non-empty level for pop
  logic pop_hit;
  logic [LW-1:0] pop_lvl;
  always_comb begin
    pop_hit = 1'b0;
    pop_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        pop_hit = 1'b1;
        pop_lvl = LW'(l);
      end
    end
  end

  logic [COST_W-1:0] rd_cost;
  assign rd_cost = rdata.is_null ? '0 : rdata.cost;

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = {3'b0, res_r.no_process, res_r.level, res_r.process_id, res_r.status};

  logic count_inc, count_dec;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    lvl_nxt = lvl_r;
    new_nxt = new_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    res_nxt = res_r;
    out_v_nxt = out_v_r;
    we = 1'b0;
    waddr = addr(lvl_r, idx_r);
    wdata = new_r;
    raddr = addr(lvl_r, idx_r);
    count_inc = 1'b0;
    count_dec = 1'b0;
    if (out_v_r && out_tready) out_v_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt = i_cmd;
          res_nxt = '0;
          new_nxt.id = i_nop ? '0 : i_pid;
          new_nxt.is_null = i_nop;
          new_nxt.cost = i_nop ? '0 : i_cost;
          state_nxt = S_DONE;
          case (i_cmd)
            CMD_PUSH: begin
              lvl_nxt = push_lvl;
              if (32'(count_r[push_lvl]) >= LEVEL_DEPTH) begin
                res_nxt.status = ST_FULL;
              end else if (i_nop || push_lvl == clamp(fifo_lvl_r)) begin
                pos_nxt = count_r[push_lvl];
                idx_nxt = count_r[push_lvl];
                state_nxt = S_SHIFT_RD;
              end else if (i_ran) begin
                pos_nxt = '0;
                idx_nxt = count_r[push_lvl];
                state_nxt = S_SHIFT_RD;
              end else begin
                idx_nxt = count_r[push_lvl];
                state_nxt = S_SCAN_RD;
              end
            end
            CMD_POP: begin
              if (!pop_hit) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                lvl_nxt = pop_lvl;
                idx_nxt = '0;
                pos_nxt = '0;
                res_nxt.level = 2'(pop_lvl);
                state_nxt = S_SCAN_RD;
              end
            end
            CMD_REMOVE: begin
              res_nxt.status = ST_NOT_FOUND;
              lvl_nxt = clamp(i_lvl);
              idx_nxt = '0;
              if (!i_nop && count_r[clamp(i_lvl)] != '0) state_nxt = S_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        // push scans from tail down (idx points one past), others from head up
        if (cmd_r == CMD_PUSH) begin
          if (idx_r == '0) begin
            pos_nxt = '0;
            idx_nxt = count_r[lvl_r];
            state_nxt = S_SHIFT_RD;
          end else begin
            raddr = addr(lvl_r, idx_r - 1'b1);
            state_nxt = S_SCAN_CHK;
          end
        end else begin
          raddr = addr(lvl_r, idx_r);
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (rd_cost < new_r.cost) begin
              pos_nxt = idx_r;
              idx_nxt = count_r[lvl_r];
              state_nxt = S_SHIFT_RD;
            end else begin
              idx_nxt = idx_r - 1'b1;
              state_nxt = S_SCAN_RD;
            end
          end
          CMD_POP: begin
            res_nxt.no_process = rdata.is_null;
            res_nxt.process_id = rdata.is_null ? '0 : rdata.id;
            res_nxt.status = ST_OK;
            idx_nxt = '0;
            state_nxt = S_SHIFT_RD;
          end
          default: begin
            if (!rdata.is_null && rdata.id == new_r.id) begin
              res_nxt.status = ST_OK;
              pos_nxt = idx_r;
              idx_nxt = idx_r;
              state_nxt = S_SHIFT_RD;
            end else if (idx_r + 1'b1 >= count_r[lvl_r]) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt = idx_r + 1'b1;
              state_nxt = S_SCAN_RD;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (cmd_r == CMD_PUSH) begin
          // move entry idx-1 to idx, from tail down to pos
          if (idx_r == pos_r) begin
            we = 1'b1;
            waddr = addr(lvl_r, pos_r);
            wdata = new_r;
            count_inc = 1'b1;
            state_nxt = S_DONE;
          end else begin
            raddr = addr(lvl_r, idx_r - 1'b1);
            state_nxt = S_SHIFT_WR;
          end
        end else begin
          // move entry idx+1 to idx, up to the tail
          if (idx_r + 1'b1 >= count_r[lvl_r]) begin
            count_dec = 1'b1;
            state_nxt = S_DONE;
          end else begin
            raddr = addr(lvl_r, idx_r + 1'b1);
            state_nxt = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = addr(lvl_r, idx_r);
        wdata = rdata;
        idx_nxt = (cmd_r == CMD_PUSH) ? idx_r - 1'b1 : idx_r + 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_DONE: begin
        out_v_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      null_lvl_r <= 2'd2;
      fifo_lvl_r <= 2'd3;
      for (int l = 0; l < LEVELS; l++) count_r[l] <= '0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NULL_LEVEL: null_lvl_r <= cfg_data;
          CFG_FIFO_LEVEL: fifo_lvl_r <= cfg_data;
          default: ;
        endcase
      end
      if (count_inc) count_r[lvl_r] <= count_r[lvl_r] + 1'b1;
      else if (count_dec) count_r[lvl_r] <= count_r[lvl_r] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    lvl_r <= lvl_nxt;
    new_r <= new_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    res_r <= res_nxt;
  end

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    count_inc |-> 32'(count_r[lvl_r]) < LEVEL_DEPTH) else $error("overfill");
  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    count_dec |-> count_r[lvl_r] != '0) else $error("underflow");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_v_r) else $error("result lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(res_r)))
    else $error("result beat changed while stalled");
endmodule
